@@ design/gbpf_pkg.sv @@
// Package: types and constants shared by the gcd unit's modules.
package gbpf_pkg;

  // Operand and result width, fixed by the item fields
  localparam int unsigned OperandWidth = 16;

  typedef logic [OperandWidth-1:0] operand_t;

  // Top-level sequencer states
  typedef enum logic [3:0] {
    StSieveRead,
    StSieveCheck,
    StSieveMark,
    StIdle,
    StPrimeRead,
    StPrimeCheck,
    StDivide,
    StDivWait,
    StResult
  } state_e;

  // Request to the divider and status it returns
  typedef struct packed {
    logic     start;
    operand_t dividend;
    operand_t divisor;
  } div_req_t;

  typedef struct packed {
    logic     done;
    operand_t quotient;
    logic     rem_zero;
  } div_rsp_t;

endpackage

@@ design/gbpf_divider.sv @@
// Restoring divider: one quotient bit per cycle.
module gbpf_divider (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  gbpf_pkg::div_req_t req_i,
  output gbpf_pkg::div_rsp_t rsp_o
);
  import gbpf_pkg::*;

  localparam int unsigned CntWidth = $clog2(OperandWidth + 1);

  logic [CntWidth-1:0] cnt_q, cnt_d;
  logic                busy_q, busy_d;
  logic                done_q, done_d;
  operand_t            quot_q, quot_d;
  operand_t            divisor_q, divisor_d;
  logic [OperandWidth:0] rem_q, rem_d;
  logic [OperandWidth:0] trial;

  always_comb begin
    cnt_d     = cnt_q;
    busy_d    = busy_q;
    done_d    = 1'b0;
    quot_d    = quot_q;
    divisor_d = divisor_q;
    rem_d     = rem_q;
    trial     = {rem_q[OperandWidth-1:0], quot_q[OperandWidth-1]}
                - {1'b0, divisor_q};
    if (req_i.start) begin
      busy_d    = 1'b1;
      cnt_d     = CntWidth'(OperandWidth);
      quot_d    = req_i.dividend;
      divisor_d = req_i.divisor;
      rem_d     = '0;
    end else if (busy_q) begin
      // shift one dividend bit in, subtract when it fits
      if (!trial[OperandWidth]) begin
        rem_d = trial;
        quot_d = {quot_q[OperandWidth-2:0], 1'b1};
      end else begin
        rem_d = {rem_q[OperandWidth-1:0], quot_q[OperandWidth-1]};
        quot_d = {quot_q[OperandWidth-2:0], 1'b0};
      end
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CntWidth'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quot_q    <= quot_d;
    divisor_q <= divisor_d;
    rem_q     <= rem_d;
  end

  assign rsp_o.done     = done_q;
  assign rsp_o.quotient = quot_q;
  assign rsp_o.rem_zero = (rem_q == '0);

endmodule

@@ design/gcd_by_prime_factorization_unit.sv @@
// Top level: gcd by prime factorisation over a sieve held in memory.
//
//  channel   direction  handshake            payload
//  command   in         start_i && !busy_o   first_operand_i, second_operand_i
//  result    out        done_o (one cycle)   common_divisor_o
//
// After reset a clearing pass writes MAX_VALUE + 1 zeros, then the sieve reads the
// flag of each candidate up to the square root and strikes the multiples of each
// prime from its square upward, with busy_o high throughout.
// An item walks candidates from 2 upward, reading each one's flag; at a prime a
// division round divides each operand by it in turn, and one round more follows
// for each factor removed.
// An operand of one or zero gives the result in the cycle after acceptance;
// busy_o falls in the cycle after that. The result cannot be stalled.
module gcd_by_prime_factorization_unit #(
  parameter int unsigned MAX_VALUE = 65535
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  output logic               busy_o,
  input  gbpf_pkg::operand_t first_operand_i,
  input  gbpf_pkg::operand_t second_operand_i,
  output logic               done_o,
  output gbpf_pkg::operand_t common_divisor_o
);
  import gbpf_pkg::*;

  localparam int unsigned AddrWidth = $clog2(MAX_VALUE + 1);
  localparam int unsigned CandWidth = AddrWidth + 1;
  localparam logic [CandWidth-1:0] MaxCand = CandWidth'(MAX_VALUE);

  // composite flags: 1 means composite; undefined store, filled by sweep
  logic comp_mem [MAX_VALUE+1];
  logic              mem_we;
  logic              mem_wdata;
  logic [AddrWidth-1:0] mem_waddr, mem_raddr;
  logic              mem_rdata_q;

  always_ff @(posedge clk_i) begin
    if (mem_we) comp_mem[mem_waddr] <= mem_wdata;
    mem_rdata_q <= comp_mem[mem_raddr];
  end

  state_e state_q, state_d;
  logic [CandWidth-1:0] p_q, p_d;        // current prime / candidate
  logic [2*CandWidth-1:0] j_q, j_d;      // sieve multiple
  operand_t a_q, a_d, b_q, b_d, g_q, g_d;
  logic     clr_ok_q, clr_ok_d;          // sweep has zeroed every entry
  logic [CandWidth-1:0] clr_q, clr_d;
  logic     div_b_q, div_b_d;            // which operand divides now
  logic     qa_ok_q, qa_ok_d;            // a divisible by p this round
  operand_t qa_q, qa_d;
  div_req_t div_req;
  div_rsp_t div_rsp;
  logic [2*CandWidth-1:0] psq;
  logic [31:0] gprod;

  gbpf_divider u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  assign psq   = {{CandWidth{1'b0}}, p_q} * {{CandWidth{1'b0}}, p_q};
  assign gprod = 32'(g_q) * 32'(p_q);

  always_comb begin
    state_d   = state_q;
    p_d = p_q; j_d = j_q; a_d = a_q; b_d = b_q; g_d = g_q;
    clr_d = clr_q; clr_ok_d = clr_ok_q;
    div_b_d = div_b_q; qa_ok_d = qa_ok_q; qa_d = qa_q;
    mem_we = 1'b0;
    mem_wdata = 1'b1;
    mem_waddr = j_q[AddrWidth-1:0];
    mem_raddr = p_q[AddrWidth-1:0];
    div_req = '{start: 1'b0, dividend: a_q, divisor: operand_t'(p_q)};
    done_o = 1'b0;
    busy_o = 1'b1;
    case (state_q)
      StSieveRead: begin
        if (!clr_ok_q) begin
          // the memory has no reset: first a clearing pass writes zeros
          mem_we    = 1'b1;
          mem_wdata = 1'b0;
          mem_waddr = clr_q[AddrWidth-1:0];
          clr_d  = clr_q + 1'b1;
          if (clr_q == MaxCand) clr_ok_d = 1'b1;
        end else if (psq > (2*CandWidth)'(MAX_VALUE)) begin
          state_d = StIdle;
        end else begin
          state_d = StSieveCheck;
        end
      end
      StSieveCheck: begin
        if (mem_rdata_q) begin
          p_d = p_q + 1'b1;
          state_d = StSieveRead;
        end else begin
          j_d = psq;
          state_d = StSieveMark;
        end
      end
      StSieveMark: begin
        mem_we = 1'b1;
        j_d = j_q + (2*CandWidth)'(p_q);
        if (j_d > (2*CandWidth)'(MAX_VALUE)) begin
          p_d = p_q + 1'b1;
          state_d = StSieveRead;
        end
      end
      StIdle: begin
        busy_o = 1'b0;
        if (start_i) begin
          a_d = first_operand_i;
          b_d = second_operand_i;
          g_d = operand_t'(1);
          p_d = CandWidth'(2);
          if (first_operand_i == operand_t'(1) || second_operand_i == operand_t'(1))
            state_d = StResult;
          else if (first_operand_i == '0) begin
            g_d = second_operand_i; state_d = StResult;
          end else if (second_operand_i == '0) begin
            g_d = first_operand_i; state_d = StResult;
          end else state_d = StPrimeRead;
        end
      end
      StPrimeRead: begin
        if (a_q <= operand_t'(1) || b_q <= operand_t'(1) || p_q > MaxCand ||
            p_q > CandWidth'(a_q) || p_q > CandWidth'(b_q))
          state_d = StResult;
        else state_d = StPrimeCheck;
      end
      StPrimeCheck: begin
        if (mem_rdata_q) begin
          p_d = p_q + 1'b1;
          state_d = StPrimeRead;
        end else begin
          div_b_d = 1'b0;
          state_d = StDivide;
        end
      end
      StDivide: begin
        div_req.start = 1'b1;
        div_req.dividend = div_b_q ? b_q : a_q;
        state_d = StDivWait;
      end
      StDivWait: begin
        if (div_rsp.done) begin
          if (!div_b_q) begin
            qa_ok_d = div_rsp.rem_zero;
            qa_d    = div_rsp.quotient;
            div_b_d = 1'b1;
            state_d = StDivide;
          end else begin
            // both divisible: shared factor; one only: strip it
            if (qa_ok_q && div_rsp.rem_zero) begin
              g_d = gprod[OperandWidth-1:0];
              a_d = qa_q; b_d = div_rsp.quotient;
            end else if (qa_ok_q) a_d = qa_q;
            else if (div_rsp.rem_zero) b_d = div_rsp.quotient;
            if (!qa_ok_q && !div_rsp.rem_zero) begin
              p_d = p_q + 1'b1;
              state_d = StPrimeRead;
            end else begin
              div_b_d = 1'b0;
              state_d = StDivide;
            end
          end
        end
      end
      StResult: begin
        done_o = 1'b1;
        state_d = StIdle;
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= StSieveRead;
      p_q      <= CandWidth'(2);
      clr_q    <= '0;
      clr_ok_q <= 1'b0;
      div_b_q  <= 1'b0;
    end else begin
      state_q  <= state_d;
      p_q      <= p_d;
      clr_q    <= clr_d;
      clr_ok_q <= clr_ok_d;
      div_b_q  <= div_b_d;
    end
  end

  always_ff @(posedge clk_i) begin
    j_q <= j_d; a_q <= a_d; b_q <= b_d; g_q <= g_d;
    qa_ok_q <= qa_ok_d; qa_q <= qa_d;
  end

  assign common_divisor_o = g_q;

endmodule

@@ design/gbpf_checker.sv @@
// Checker: port-level properties of the gcd unit, bound to the top level.
module gbpf_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               start_i,
  input logic               busy_o,
  input logic               done_o,
  input gbpf_pkg::operand_t first_operand_i,
  input gbpf_pkg::operand_t second_operand_i,
  input gbpf_pkg::operand_t common_divisor_o
);
  import gbpf_pkg::*;

  // an accepted item keeps the unit busy in the next cycle
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |=> busy_o) else $error("accept without busy");

  // a result is only shown while busy
  a_done_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> busy_o) else $error("result while idle");

  // the result strobe lasts one cycle
  a_done_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o) else $error("result strobe held");

  // a first operand of one gives a result of one in the next cycle
  a_one: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o && first_operand_i == operand_t'(1)) |=>
    (done_o && common_divisor_o == operand_t'(1))) else $error("gcd with one");

endmodule

bind gcd_by_prime_factorization_unit gbpf_checker u_gbpf_checker (.*);

@@ tb/sv/gcd_by_prime_factorization_unit_test.sv @@
// Testbench: checks gcd results from the prime-factorisation unit against a local gcd model.
`timescale 1ns / 100ps

module gcd_by_prime_factorization_unit_test;
  import gbpf_pkg::*;

  localparam int unsigned CycleLimit = 100_000_000;
  localparam int unsigned DrainCycles = 50;

  logic     clk_i;
  logic     rst_ni;
  logic     start_i;
  logic     busy_o;
  operand_t first_operand_i;
  operand_t second_operand_i;
  logic     done_o;
  operand_t common_divisor_o;

  // Expected gcd values, oldest first
  operand_t    gcd_expected_q[$];
  int unsigned mismatch_count;
  int unsigned gcd_checked;
  int unsigned items_sent;
  int unsigned cycle_count;
  bit          gaps_enabled;

  gcd_by_prime_factorization_unit i_dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .start_i          (start_i),
    .busy_o           (busy_o),
    .first_operand_i  (first_operand_i),
    .second_operand_i (second_operand_i),
    .done_o           (done_o),
    .common_divisor_o (common_divisor_o)
  );

  // Clock, 10 ns period
  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  // gcd with gcd(0, x) = x; an operand of one always gives one
  function automatic operand_t predict_gcd(operand_t a, operand_t b);
    logic [15:0] x;
    logic [15:0] y;
    logic [15:0] t;
    x = a;
    y = b;
    while (y != 16'd0) begin
      t = x % y;
      x = y;
      y = t;
    end
    return x;
  endfunction

  // Send one item: hold start until accepted, then maybe leave a gap
  task automatic send_pair(input operand_t a, input operand_t b);
    int unsigned gap;
    start_i          <= 1'b1;
    first_operand_i  <= a;
    second_operand_i <= b;
    do @(posedge clk_i); while (busy_o);
    gcd_expected_q.insert(gcd_expected_q.size(), predict_gcd(a, b));
    items_sent++;
    if (gaps_enabled && ($urandom_range(0, 99) < 25)) begin
      gap = $urandom_range(1, 6);
      start_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // Result checker; the receiver cannot stall, so every strobe is taken
  always @(posedge clk_i) begin
    if (rst_ni && done_o) begin
      if (gcd_expected_q.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("unexpected result: common_divisor=%0d", common_divisor_o);
      end else begin
        if (common_divisor_o !== gcd_expected_q[0]) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("mismatch: common_divisor expected %0d got %0d",
                     gcd_expected_q[0], common_divisor_o);
        end
        void'(gcd_expected_q.pop_front());
        gcd_checked++;
      end
    end
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("** gcd_by_prime_factorization_unit: FAILED **");
      $finish;
    end
  end

  // Field extremes, including all-ones and large primes
  task automatic test_extremes();
    send_pair(16'd65535, 16'd65535);
    send_pair(16'd65535, 16'd255);
    send_pair(16'd32768, 16'd65535);
    send_pair(16'd32768, 16'd49152);
    send_pair(16'd2, 16'd2);
    send_pair(16'd2, 16'd3);
    send_pair(16'd65521, 16'd65521);
    send_pair(16'd65534, 16'd32767);
    send_pair(16'd43690, 16'd21845);
  endtask

  // Operand of one gives one whatever the other is
  task automatic test_unit_operand();
    send_pair(16'd1, 16'd1);
    send_pair(16'd1, 16'd65535);
    send_pair(16'd60000, 16'd1);
    send_pair(16'd1, 16'd65521);
  endtask

  // Zero operand: result is the other operand
  task automatic test_zero_operand();
    send_pair(16'd0, 16'd12);
    send_pair(16'd36, 16'd0);
    send_pair(16'd0, 16'd0);
  endtask

  // Repeated and shared prime factors with differing multiplicities
  task automatic test_shared_factors();
    send_pair(16'd72, 16'd108);
    send_pair(16'd1024, 16'd96);
    send_pair(16'd3375, 16'd2025);
    send_pair(16'd221, 16'd323);
    send_pair(16'd97, 16'd194);
  endtask

  // Random items: mostly a common factor times small cofactors, some noise
  task automatic test_random_pairs(input int unsigned count);
    logic [31:0] common;
    logic [31:0] a;
    logic [31:0] b;
    for (int unsigned n = 0; n < count; n++) begin
      if (n == count / 3) gaps_enabled = 1'b0;      // stretch with no gaps
      if (n == count / 2) gaps_enabled = 1'b1;
      if ($urandom_range(0, 99) < 80) begin
        common = $urandom_range(1, 64);
        a = common * $urandom_range(1, 400);
        b = common * $urandom_range(1, 400);
        if ($urandom_range(0, 9) == 0) a = a << $urandom_range(1, 5);
      end else begin
        a = $urandom_range(1, 4095);
        b = $urandom_range(1, 4095);
      end
      if (a > 32'd65535) a = 32'd65535;
      if (b > 32'd65535) b = 32'd65535;
      send_pair(operand_t'(a), operand_t'(b));
    end
  endtask

  initial begin
    rst_ni           = 1'b0;
    start_i          = 1'b0;
    first_operand_i  = '0;
    second_operand_i = '0;
    mismatch_count   = 0;
    gcd_checked      = 0;
    items_sent       = 0;
    cycle_count      = 0;
    gaps_enabled     = 1'b1;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    test_extremes();
    test_unit_operand();
    test_zero_operand();
    test_shared_factors();
    test_random_pairs(100);
    start_i <= 1'b0;

    // Drain outstanding results, then a short quiet period
    while (gcd_expected_q.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    $display("sent %0d operand pairs, checked %0d results, %0d mismatches",
             items_sent, gcd_checked, mismatch_count);
    $display("covered extremes, unit and zero operands, shared factors, random pairs");
    if (mismatch_count == 0 && gcd_expected_q.size() == 0)
      $display("** gcd_by_prime_factorization_unit: PASSED **");
    else
      $display("** gcd_by_prime_factorization_unit: FAILED **");
    $finish;
  end

endmodule
